>>> rtl/fpp_pkg.sv
`timescale 1ns / 1ps

package fpp_pkg;

  // Field widths of the byte stream and the result item
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned CNT_W    = 16;

  // Packed stream widths
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 3;

  // Payload limit default and the modulus of the check sums
  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam logic [8:0]  MODULUS         = 9'd255;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd1;

  // Configuration register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_VALID   = 2'd0,
    ST_LEN_BIG = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_NO_END  = 2'd3
  } status_t;

  // Framing bytes handed from the register file to the parser
  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  // Add a byte to a running sum modulo 255; the sum stays below twice the modulus
  function automatic logic [BYTE_W-1:0] add_mod(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MODULUS) begin
      s = s - MODULUS;
    end
    return s[BYTE_W-1:0];
  endfunction

endpackage

>>> rtl/fpp_buf.sv
`timescale 1ns / 1ps

module fpp_buf #(
  parameter int unsigned DEPTH = fpp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fpp_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [fpp_pkg::BYTE_W-1:0] rd_data
);

  logic [fpp_pkg::BYTE_W-1:0] mem [DEPTH];

  // Write one payload byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/fpp_ctrl.sv
`timescale 1ns / 1ps

module fpp_ctrl #(
  parameter int unsigned MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpp_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fpp_pkg::BYTE_W-1:0]   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fpp_pkg::status_t             out_status,
  output logic [fpp_pkg::BYTE_W-1:0]   out_command,
  output logic [fpp_pkg::LEN_W-1:0]    out_length,
  output logic [fpp_pkg::BYTE_W-1:0]   out_pbyte,
  output logic                         out_pvalid,
  output logic                         out_last,
  output logic [fpp_pkg::CNT_W-1:0]    good_count,
  output logic [fpp_pkg::CNT_W-1:0]    bad_count
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0]  MAX_LEN = 9'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_LEN,
    S_DATA,
    S_CLO,
    S_CHI,
    S_END,
    S_RD,
    S_WAIT
  } state_t;

  state_t                        state;
  logic [fpp_pkg::BYTE_W-1:0]    command_reg;
  logic [fpp_pkg::LEN_W-1:0]     length_reg;
  logic [fpp_pkg::LEN_W-1:0]     byte_count;
  logic [fpp_pkg::LEN_W-1:0]     rd_idx;
  logic [15:0]                   received_check;
  logic [fpp_pkg::BYTE_W-1:0]    sum_low;
  logic [fpp_pkg::BYTE_W-1:0]    sum_high;

  logic                          in_fire;
  logic                          out_free;
  logic                          out_load;
  logic [fpp_pkg::BYTE_W-1:0]    sum_low_next;
  logic [fpp_pkg::BYTE_W-1:0]    sum_high_next;
  logic [fpp_pkg::LEN_W-1:0]     byte_count_next;
  logic [fpp_pkg::LEN_W-1:0]     rd_idx_next;
  logic                          len_big;
  logic [fpp_pkg::LEN_W-1:0]     len_sat;
  logic                          wr_en;
  logic                          rd_en;
  logic [fpp_pkg::BYTE_W-1:0]    rd_data;

  // Output slot is free when empty or drained this cycle
  assign out_free = !out_valid || out_ready;

  // Take bytes while parsing; result-producing positions need a free slot
  always_comb begin
    unique case (state)
      S_LEN, S_END:  in_ready = out_free;
      S_RD, S_WAIT:  in_ready = 1'b0;
      default:       in_ready = 1'b1;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // Check sums and counters for the current byte
  always_comb begin
    sum_low_next    = fpp_pkg::add_mod(sum_low, in_byte);
    sum_high_next   = fpp_pkg::add_mod(sum_high, sum_low_next);
    byte_count_next = byte_count + 7'd1;
    rd_idx_next     = rd_idx + 7'd1;
    len_big         = {1'b0, in_byte} > MAX_LEN;
    len_sat         = in_byte[7] ? 7'h7f : in_byte[fpp_pkg::LEN_W-1:0];
  end

  // Load a result on a rejected frame, an empty good frame or a replayed byte
  always_comb begin
    unique case (state)
      S_LEN:   out_load = in_fire && len_big;
      S_END:   out_load = in_fire && ((in_byte != cfg.end_byte) ||
                                      ({sum_high, sum_low} != received_check) ||
                                      (length_reg == '0));
      S_WAIT:  out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // Payload memory: fill during the data phase, read back on replay
  assign wr_en = in_fire && (state == S_DATA);
  assign rd_en = (state == S_RD);

  fpp_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Parser state, sums, counters and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      good_count     <= '0;
      bad_count      <= '0;
      command_reg    <= '0;
      length_reg     <= '0;
      byte_count     <= '0;
      rd_idx         <= '0;
      received_check <= '0;
      sum_low        <= '0;
      sum_high       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && (in_byte == cfg.start_byte)) begin
            state          <= S_CMD;
            command_reg    <= '0;
            length_reg     <= '0;
            byte_count     <= '0;
            received_check <= '0;
            sum_low        <= '0;
            sum_high       <= '0;
          end
        end
        S_CMD: begin
          if (in_fire) begin
            command_reg <= in_byte;
            sum_low     <= sum_low_next;
            sum_high    <= sum_high_next;
            state       <= S_LEN;
          end
        end
        S_LEN: begin
          if (in_fire) begin
            if (len_big) begin
              // Reject oversize length right away
              bad_count   <= bad_count + 16'd1;
              out_status  <= fpp_pkg::ST_LEN_BIG;
              out_command <= command_reg;
              out_length  <= len_sat;
              out_pbyte   <= '0;
              out_pvalid  <= 1'b0;
              out_last    <= 1'b1;
              state       <= S_IDLE;
            end else begin
              length_reg <= in_byte[fpp_pkg::LEN_W-1:0];
              sum_low    <= sum_low_next;
              sum_high   <= sum_high_next;
              byte_count <= '0;
              state      <= (in_byte == '0) ? S_CLO : S_DATA;
            end
          end
        end
        S_DATA: begin
          if (in_fire) begin
            sum_low    <= sum_low_next;
            sum_high   <= sum_high_next;
            byte_count <= byte_count_next;
            if (byte_count_next >= length_reg) begin
              state <= S_CLO;
            end
          end
        end
        S_CLO: begin
          if (in_fire) begin
            received_check[7:0] <= in_byte;
            state               <= S_CHI;
          end
        end
        S_CHI: begin
          if (in_fire) begin
            received_check[15:8] <= in_byte;
            state                <= S_END;
          end
        end
        S_END: begin
          if (in_fire) begin
            out_command <= command_reg;
            out_length  <= length_reg;
            out_pbyte   <= '0;
            out_pvalid  <= 1'b0;
            out_last    <= 1'b1;
            if (in_byte != cfg.end_byte) begin
              bad_count  <= bad_count + 16'd1;
              out_status <= fpp_pkg::ST_NO_END;
              state      <= S_IDLE;
            end else if ({sum_high, sum_low} != received_check) begin
              bad_count  <= bad_count + 16'd1;
              out_status <= fpp_pkg::ST_BAD_SUM;
              state      <= S_IDLE;
            end else begin
              good_count <= good_count + 16'd1;
              out_status <= fpp_pkg::ST_VALID;
              if (length_reg == '0) begin
                state <= S_IDLE;
              end else begin
                rd_idx <= '0;
                state  <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          // Load one replayed byte once the slot frees up
          if (out_free) begin
            out_pbyte  <= rd_data;
            out_pvalid <= 1'b1;
            out_last   <= (rd_idx_next == length_reg);
            if (rd_idx_next == length_reg) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx_next;
              state  <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No byte is taken while a frame replays
  a_no_input_on_replay: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WAIT) |-> !in_ready)
    else $error("input taken during replay");

  // Counters hold while a result waits at the output
  a_counts_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(good_count) && $stable(bad_count)))
    else $error("frame counter moved under a stalled result");

  // Data phase never runs past the frame length
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (byte_count < length_reg))
    else $error("payload fill past frame length");

  // Replay reads stay inside the written part of the buffer
  a_replay_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WAIT) |-> (rd_idx < length_reg))
    else $error("replay read past frame length");

endmodule

>>> rtl/framed_packet_parser_fletcher16.sv
`timescale 1ns / 1ps

// Framed packet parser with a Fletcher-16 check. Bytes enter on the slave
// stream one per transfer: the parser hunts for the start byte, then takes a
// command byte, a length byte (at most MAX_PAYLOAD), the payload, the check
// value low then high byte, and the end byte; the two sums run modulo 255 over
// command, length and payload. While parsing, one byte is taken every cycle,
// but the length and end positions wait for a free output slot. A good frame
// is replayed from the payload memory as one result per payload byte (tlast
// on the final one), or as a single result when empty; each byte passes the
// registered payload memory read, then the output register load, and no byte
// is taken until the replay ends. A rejected frame gives one error result.
// Results sit in one output register, so bytes keep flowing while a result
// waits. The payload memory needs no clearing after reset. The user writes
// the framing bytes through the configuration channel only while the block
// is idle; the block itself does not enforce it.
module framed_packet_parser_fletcher16 #(
  parameter int unsigned MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpp_pkg::BYTE_W-1:0]       cfg_data,
  // received bytes
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fpp_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
  // parse results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] frame_command, [14:8] frame_length, [22:15] payload_byte,
  // [38:23] good_frames, [54:39] bad_frames, [55] zero
  output logic [fpp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [fpp_pkg::OUT_USER_W-1:0]   m_axis_tuser,   // [1:0] status, [2] payload_valid
  output logic                             m_axis_tlast
);

  fpp_pkg::cfg_t                   cfg;
  fpp_pkg::status_t                out_status;
  logic [fpp_pkg::BYTE_W-1:0]      out_command;
  logic [fpp_pkg::LEN_W-1:0]       out_length;
  logic [fpp_pkg::BYTE_W-1:0]      out_pbyte;
  logic                            out_pvalid;
  logic [fpp_pkg::CNT_W-1:0]       good_count;
  logic [fpp_pkg::CNT_W-1:0]       bad_count;

  assign cfg_ready = 1'b1;

  // Framing byte registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= fpp_pkg::START_BYTE_RST;
      cfg.end_byte   <= fpp_pkg::END_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpp_pkg::REG_START: cfg.start_byte <= cfg_data;
        fpp_pkg::REG_END:   cfg.end_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  fpp_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (out_status),
    .out_command (out_command),
    .out_length  (out_length),
    .out_pbyte   (out_pbyte),
    .out_pvalid  (out_pvalid),
    .out_last    (m_axis_tlast),
    .good_count  (good_count),
    .bad_count   (bad_count)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {1'b0, bad_count, good_count, out_pbyte, out_length, out_command};
  assign m_axis_tuser = {out_pvalid, out_status};

endmodule
